// ===== src/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every rising edge outside reset.
`define PTS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("scheduler check failed");
// Check that a condition never holds at a rising edge outside reset.
`define PTS_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("scheduler forbidden condition seen");
`else
`define PTS_ASSERT(lbl, clk, rst_n, prop)
`define PTS_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== src/pts_pkg.sv =====
// Types, codes and constants of the priority task scheduler.
`default_nettype none
package pts_pkg;
	localparam int MaxTasks = 16;
	localparam int SlotW    = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
	localparam int CntW     = $clog2(MaxTasks + 1);

	localparam logic [7:0] CeilingReset = 8'd10;

	localparam logic [1:0] ACT_CREATE   = 2'd0;
	localparam logic [1:0] ACT_WAIT     = 2'd1;
	localparam logic [1:0] ACT_START    = 2'd2;
	localparam logic [1:0] ACT_SCHEDULE = 2'd3;

	localparam logic [1:0] STAT_DISPATCHED = 2'd0;
	localparam logic [1:0] STAT_NONE_READY = 2'd1;
	localparam logic [1:0] STAT_CREATED    = 2'd2;
	localparam logic [1:0] STAT_FULL       = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] priority_req;
		logic [7:0] task_id;
	} pts_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] slot;
		logic [7:0] chosen_id;
	} pts_rsp_t;

	// Control of the best-candidate tracker for one scan step.
	typedef struct packed {
		logic init;
		logic vld;
		logic elig;
	} pts_ctl_t;

	// Report only the low four bits of a slot index.
	function automatic logic [3:0] slot_out(input logic [SlotW-1:0] s);
		logic [31:0] w;
		w = 32'(s);
		return w[3:0];
	endfunction
endpackage
`default_nettype wire

// ===== src/pts_table.sv =====
// Priority and identifier store of the task table, one write and one read port.
`default_nettype none
module pts_table (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [pts_pkg::SlotW-1:0] waddr,
	input  wire logic [7:0]                wprio,
	input  wire logic [7:0]                wid,
	input  wire logic [pts_pkg::SlotW-1:0] raddr,
	output logic      [7:0]                rd_prio,
	output logic      [7:0]                rd_id
);
	import pts_pkg::*;

	logic [7:0] prio_mem [MaxTasks];
	logic [7:0] id_mem [MaxTasks];

	always_ff @(posedge clk) begin
		if (we) begin
			prio_mem[waddr] <= wprio;
			id_mem[waddr]   <= wid;
		end
	end

	always_ff @(posedge clk) begin
		rd_prio <= prio_mem[raddr];
		rd_id   <= id_mem[raddr];
	end
endmodule
`default_nettype wire

// ===== src/pts_best.sv =====
// Shared compare unit: tracks the best eligible entry over a scan.
`default_nettype none
module pts_best (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire pts_pkg::pts_ctl_t         ctl,
	input  wire logic [7:0]                ceiling,
	input  wire logic [7:0]                prio,
	input  wire logic [7:0]                id,
	input  wire logic [pts_pkg::SlotW-1:0] idx,
	output logic                           found,
	output logic      [pts_pkg::SlotW-1:0] best_idx,
	output logic      [7:0]                best_id
);
	import pts_pkg::*;

	logic [7:0] limit_q;
	logic       found_q;
	logic       take;

	// At or below the running limit: a tie goes to the later slot.
	assign take = ctl.vld && ctl.elig && (prio <= limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			limit_q <= CeilingReset;
		end else if (ctl.init) begin
			found_q <= 1'b0;
			limit_q <= ceiling;
		end else if (take) begin
			found_q <= 1'b1;
			limit_q <= prio;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx <= idx;
			best_id  <= id;
		end
	end

	assign found = found_q;
endmodule
`default_nettype wire

// ===== src/priority_task_scheduler_unit.sv =====
// Top level of the priority task scheduler: sequencer, ready marks and result register.
//
// Usage:
//   Request channel: drive req and raise start; the request is taken at a rising
//   edge where start is high and busy is low.
//   Result channel: done pulses for one cycle with rsp; the receiver cannot stall,
//   so it must take the result in that cycle.
//   Configuration: cfg_we with cfg_data writes priority_ceiling; write only while idle.
// Request handling:
//   Create answers in the cycle after the request and leaves busy low, so a new
//   request may follow in the next cycle.
//   Wait, start and schedule scan the occupied entries one per cycle through the
//   table read port and one shared compare unit: the result is registered after the
//   scan, the drain state and the finish state (an empty table answers from idle),
//   and busy stays high until the cycle the result appears.
//   A start request matches identifiers in the same pass as the priority search.
// Reset:
//   arst_n clears the ready marks, entry count, current slot and sequencer, and
//   loads priority_ceiling with 10. The store contents stay unknown until written.
`default_nettype none
`include "assert_macros.svh"
module priority_task_scheduler_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire pts_pkg::pts_req_t req,
	output logic                   done,
	output pts_pkg::pts_rsp_t      rsp,
	input  wire logic              cfg_we,
	input  wire logic [7:0]        cfg_data
);
	import pts_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DRAIN  = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0]          state_q;
	logic [7:0]          ceiling_q;
	logic [CntW-1:0]     cnt_q;
	logic [SlotW-1:0]    cur_q;
	logic [MaxTasks-1:0] ready_q;
	logic [SlotW-1:0]    idx_q;
	logic                start_op_q;
	logic [7:0]          tid_q;
	logic                vld_s1;
	logic [SlotW-1:0]    idx_s1;
	logic                done_q;
	pts_rsp_t            rsp_q;

	logic             accept;
	logic             full;
	logic             do_create;
	logic             last_issue;
	logic [7:0]       rd_prio;
	logic [7:0]       rd_id;
	logic             id_hit;
	pts_ctl_t         ctl;
	logic             found;
	logic [SlotW-1:0] best_idx;
	logic [7:0]       best_id;

	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign full       = (cnt_q >= CntW'(MaxTasks));
	assign do_create  = accept && (req.action == ACT_CREATE) && !full;
	assign last_issue = ((CntW'(idx_q) + CntW'(1)) == cnt_q);

	// A start request readies the entry being compared if its identifier matches.
	assign id_hit   = start_op_q && (rd_id == tid_q);
	assign ctl.init = accept && (req.action != ACT_CREATE);
	assign ctl.vld  = vld_s1;
	assign ctl.elig = ready_q[idx_s1] || id_hit;

	pts_table u_table (
		.clk     (clk),
		.we      (do_create),
		.waddr   (cnt_q[SlotW-1:0]),
		.wprio   (req.priority_req),
		.wid     (req.task_id),
		.raddr   (idx_q),
		.rd_prio (rd_prio),
		.rd_id   (rd_id)
	);

	pts_best u_best (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.ceiling  (ceiling_q),
		.prio     (rd_prio),
		.id       (rd_id),
		.idx      (idx_s1),
		.found    (found),
		.best_idx (best_idx),
		.best_id  (best_id)
	);

	// Hold the ceiling register; the user must make writes come only while idle, as the block takes cfg_we unchecked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q <= CeilingReset;
		end else if (cfg_we) begin
			ceiling_q <= cfg_data;
		end
	end

	// Ready marks: set on create and on identifier match, clear on wait.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= '0;
		end else begin
			if (do_create) begin
				ready_q[cnt_q[SlotW-1:0]] <= 1'b1;
			end
			if (accept && (req.action == ACT_WAIT)) begin
				ready_q[cur_q] <= 1'b0;
			end
			if (vld_s1 && id_hit) begin
				ready_q[idx_s1] <= 1'b1;
			end
		end
	end

	// Sequencer: issue one table read per cycle, then drain the compare stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			cur_q      <= '0;
			idx_q      <= '0;
			start_op_q <= 1'b0;
			tid_q      <= '0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= (state_q == S_SCAN);
			idx_s1 <= idx_q;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.action == ACT_CREATE) begin
							done_q <= 1'b1;
							if (!full) begin
								cnt_q <= cnt_q + CntW'(1);
							end
						end else begin
							start_op_q <= (req.action == ACT_START);
							tid_q      <= req.task_id;
							idx_q      <= '0;
							if (cnt_q == '0) begin
								done_q <= 1'b1;
							end else begin
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + SlotW'(1);
					if (last_issue) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (found) begin
						cur_q <= best_idx;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result register: loaded in the cycle that raises done.
	always_ff @(posedge clk) begin
		if (accept && (req.action == ACT_CREATE)) begin
			if (full) begin
				rsp_q <= '{status: STAT_FULL, slot: 4'd0, chosen_id: 8'd0};
			end else begin
				rsp_q <= '{status: STAT_CREATED, slot: slot_out(cnt_q[SlotW-1:0]),
					chosen_id: req.task_id};
			end
		end else if (accept && (cnt_q == '0)) begin
			rsp_q <= '{status: STAT_NONE_READY, slot: slot_out(cur_q), chosen_id: 8'd0};
		end else if (state_q == S_FINISH) begin
			if (found) begin
				rsp_q <= '{status: STAT_DISPATCHED, slot: slot_out(best_idx),
					chosen_id: best_id};
			end else begin
				rsp_q <= '{status: STAT_NONE_READY, slot: slot_out(cur_q),
					chosen_id: 8'd0};
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`PTS_ASSERT(a_done_has_cause, clk, arst_n, done |-> ($past(start && !busy) || $past(busy)))
	`PTS_ASSERT(a_busy_ends_in_done, clk, arst_n, $fell(busy) |-> done)
	`PTS_NEVER(a_count_in_range, clk, arst_n, cnt_q > CntW'(MaxTasks))
	`PTS_ASSERT(a_dispatch_is_ready, clk, arst_n, (done && (rsp.status == STAT_DISPATCHED)) |-> ready_q[cur_q])
endmodule
`default_nettype wire
